### rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  // Screen geometry defaults
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // Fixed field widths
  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int COL_FIELD_W = 7;
  localparam int ROW_FIELD_W = 5;
  localparam int ATTR_W      = 8;
  localparam int CURSOR_W    = 11;
  localparam int CELL_W      = CHAR_W + ATTR_W;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

### rtl/tcw_screen_ram.sv
`default_nettype none
module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(DEPTH)-1:0]    waddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]    raddr,
  output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/text_console_writer.sv
`default_nettype none
// Channel   | Direction | Handshake             | Contents
// ----------+-----------+-----------------------+---------------------------------------------
// request   | in        | in_valid / in_ready   | mode, character, col, row, attribute, at_cursor
// result    | out       | out_valid / out_ready | cursor, cell_char, cell_attribute, out_of_range
// config    | in        | cfg_write_en          | cfg_write_data -> default attribute
//
// Put: execute step, then finish step; read: execute, read, then finish step.
// Clear: every cell swept one a cycle in the fill step, then the finish step.
// Scrolling put: rows copied up cell by cell in the scroll and drain steps, then the finish step.
// Reset: a clearing pass zeroes every cell of the store with in_ready low.
// One request in work at a time; the one-cell-a-cycle store and the shared multiplier set this.
// Stall: a result waiting in the output register holds only the finish step.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tcw_pkg::MODE_W-1:0]       mode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       character,
  input  wire logic [tcw_pkg::COL_FIELD_W-1:0]  col,
  input  wire logic [tcw_pkg::ROW_FIELD_W-1:0]  row,
  input  wire logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  wire logic                             at_cursor,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [tcw_pkg::CURSOR_W-1:0]     cursor,
  output logic      [tcw_pkg::CHAR_W-1:0]       cell_char,
  output logic      [tcw_pkg::ATTR_W-1:0]       cell_attribute,
  output logic                                  out_of_range,
  // configuration
  input  wire logic                             cfg_write_en,
  input  wire logic [tcw_pkg::ATTR_W-1:0]       cfg_write_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  tcw_pkg::state_t state, state_next;

  // Cursor kept as row and column, so newline and wrap need no division
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [tcw_pkg::ATTR_W-1:0] def_attr;

  // Latched request
  logic [tcw_pkg::MODE_W-1:0] op_mode;
  logic [tcw_pkg::CHAR_W-1:0] op_char;
  logic [tcw_pkg::ATTR_W-1:0] op_attr;
  logic [COL_W-1:0]           op_col;
  logic [ROW_W-1:0]           op_row;
  logic                       op_bad;

  // Sweep counter and scroll write-back pipeline
  logic [ADDR_W-1:0] idx;
  logic              sc_pend;
  logic [ADDR_W-1:0] sc_addr;
  logic              sc_zero;

  // Result staging
  logic [tcw_pkg::CHAR_W-1:0] rd_char;
  logic [tcw_pkg::ATTR_W-1:0] rd_attr;
  logic                       res_oor;

  // Store port
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic in_fire;
  logic finish_go;
  logic bad_col, bad_row;

  // Shared multiplier: row*COLUMNS+col for the target cell, or the cursor on finish
  logic [COL_W-1:0]  mul_col;
  logic [ROW_W-1:0]  mul_row;
  logic [ADDR_W-1:0] mul_idx;

  // Put step decode
  logic             is_nl, is_bs, wrap_col, last_row;
  logic             row_step;
  logic [COL_W-1:0] new_col;
  logic [ROW_W-1:0] new_row;
  logic             need_scroll;
  logic             sweep_last;

  assign in_fire   = in_valid && in_ready;
  assign finish_go = !out_valid || out_ready;
  assign bad_col   = {1'b0, col} >= (tcw_pkg::COL_FIELD_W + 1)'(COLUMNS);
  assign bad_row   = {1'b0, row} >= (tcw_pkg::ROW_FIELD_W + 1)'(ROWS);

  assign mul_row = (state == tcw_pkg::ST_FINISH) ? cur_row : op_row;
  assign mul_col = (state == tcw_pkg::ST_FINISH) ? cur_col : op_col;
  assign mul_idx = ADDR_W'(mul_row) * ADDR_W'(COLUMNS) + ADDR_W'(mul_col);

  assign sweep_last = (idx == ADDR_W'(CELLS - 1));

  // Work out where the cursor lands after a put
  always_comb begin
    is_nl    = (op_char == tcw_pkg::CH_NEWLINE);
    is_bs    = (op_char == tcw_pkg::CH_BACKSPACE);
    wrap_col = (op_col == COL_W'(COLUMNS - 1));
    last_row = (op_row == ROW_W'(ROWS - 1));
    if (is_nl) begin
      new_col  = '0;
      row_step = 1'b1;
    end else if (is_bs) begin
      new_col  = op_col;
      row_step = 1'b0;
    end else if (wrap_col) begin
      new_col  = '0;
      row_step = 1'b1;
    end else begin
      new_col  = op_col + COL_W'(1);
      row_step = 1'b0;
    end
    // Running off the bottom holds the cursor on the last row and scrolls
    need_scroll = row_step && last_row;
    new_row     = (row_step && !last_row) ? op_row + ROW_W'(1) : op_row;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        if (sweep_last) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        if (op_mode == tcw_pkg::MODE_PUT && !op_bad) begin
          state_next = need_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_FINISH;
        end else if (op_mode == tcw_pkg::MODE_READ && !op_bad) begin
          state_next = tcw_pkg::ST_READ;
        end else if (op_mode == tcw_pkg::MODE_CLEAR) begin
          state_next = tcw_pkg::ST_FILL;
        end else begin
          state_next = tcw_pkg::ST_FINISH;
        end
      end
      tcw_pkg::ST_READ:   state_next = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_SCROLL: begin
        if (sweep_last) state_next = tcw_pkg::ST_DRAIN;
      end
      tcw_pkg::ST_DRAIN:  state_next = tcw_pkg::ST_FINISH;
      tcw_pkg::ST_FILL: begin
        if (sweep_last) state_next = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_FINISH: begin
        if (finish_go) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  // Store port control and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = mul_idx;
    case (state)
      tcw_pkg::ST_INIT: begin
        ram_we = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      tcw_pkg::ST_EXEC: begin
        // Newline writes nothing; backspace blanks the cell
        ram_we    = (op_mode == tcw_pkg::MODE_PUT) && !op_bad && !is_nl;
        ram_waddr = mul_idx;
        ram_wdata = {op_attr, is_bs ? tcw_pkg::CH_SPACE : op_char};
      end
      tcw_pkg::ST_SCROLL, tcw_pkg::ST_DRAIN: begin
        // Read one row ahead, write back behind; the last row comes back zero
        ram_raddr = idx + ADDR_W'(COLUMNS);
        ram_we    = sc_pend;
        ram_waddr = sc_addr;
        ram_wdata = sc_zero ? '0 : ram_rdata;
      end
      tcw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {def_attr, tcw_pkg::CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      cur_col   <= '0;
      cur_row   <= '0;
      def_attr  <= tcw_pkg::DEFAULT_ATTR_RESET;
      idx       <= '0;
      sc_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      sc_pend <= (state == tcw_pkg::ST_SCROLL);
      if (cfg_write_en) begin
        def_attr <= cfg_write_data;
      end
      // Advance the sweep; restart it for every request
      if (state == tcw_pkg::ST_EXEC) begin
        idx <= '0;
      end else if (state == tcw_pkg::ST_INIT || state == tcw_pkg::ST_SCROLL ||
                   state == tcw_pkg::ST_FILL) begin
        idx <= idx + ADDR_W'(1);
      end
      if (state == tcw_pkg::ST_EXEC) begin
        if (op_mode == tcw_pkg::MODE_PUT && !op_bad) begin
          cur_col <= new_col;
          cur_row <= new_row;
        end else if (op_mode == tcw_pkg::MODE_CLEAR) begin
          cur_col <= '0;
          cur_row <= '0;
        end
      end
      if (state == tcw_pkg::ST_FINISH && finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_mode <= mode;
      op_char <= character;
      op_attr <= (attribute == '0) ? def_attr : attribute;
      op_bad  <= !at_cursor && (bad_col || bad_row);
      op_col  <= at_cursor ? cur_col : col[COL_W-1:0];
      op_row  <= at_cursor ? cur_row : row[ROW_W-1:0];
    end
    sc_addr <= idx;
    sc_zero <= idx >= ADDR_W'(CELLS - COLUMNS);
    if (state == tcw_pkg::ST_EXEC) begin
      rd_char <= '0;
      rd_attr <= '0;
      res_oor <= op_bad &&
                 (op_mode == tcw_pkg::MODE_PUT || op_mode == tcw_pkg::MODE_READ);
    end else if (state == tcw_pkg::ST_READ) begin
      rd_char <= ram_rdata[tcw_pkg::CHAR_W-1:0];
      rd_attr <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
    end
    // Load the output register once it is free
    if (state == tcw_pkg::ST_FINISH && finish_go) begin
      cursor         <= tcw_pkg::CURSOR_W'(mul_idx);
      cell_char      <= rd_char;
      cell_attribute <= rd_attr;
      out_of_range   <= res_oor;
    end
  end

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= COL_W'(COLUMNS - 1)) && (cur_row <= ROW_W'(ROWS - 1)))
    else $error("cursor left the screen");

  // No store write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // Scroll never reads the cell it is writing back
  a_scroll_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_SCROLL && sc_pend) |-> (ram_raddr != ram_waddr))
    else $error("scroll read and write collide");

  // A result appears only from the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == tcw_pkg::ST_FINISH))
    else $error("result raised outside finish");

  // An accepted request always goes to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == tcw_pkg::ST_EXEC))
    else $error("accepted request not executed");

endmodule
`default_nettype wire
